// ===== rtl/core/saa_pkg.sv =====
// Shared constants, types and command codes of the subnet address allocator.
package saa_pkg;

  localparam int MAX_HOST_BITS = 8;
  localparam int ADDR_W        = 32;
  localparam int PFX_W         = 5;
  localparam int LVL_CNT       = MAX_HOST_BITS + 1;
  localparam int LVL_W         = $clog2(LVL_CNT);
  localparam int NODE_W        = MAX_HOST_BITS;
  localparam int PAIR_W        = (MAX_HOST_BITS > 1) ? MAX_HOST_BITS - 1 : 1;
  localparam int PAIR_CNT      = 2 ** PAIR_W;
  localparam int CNT_W         = MAX_HOST_BITS + 1;
  localparam int CFG_IDX_W     = 1;

  localparam logic [PFX_W-1:0] PREFIX_RST = PFX_W'(24);
  localparam logic [CNT_W-1:0] TAKEN_RST  = CNT_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUBNET_BASE   = 1'b0,
    CFG_PREFIX_LENGTH = 1'b1
  } saa_cfg_idx_t;

  typedef enum logic {
    REQ_ALLOC   = 1'b0,
    REQ_RELEASE = 1'b1
  } saa_req_type_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RESERVED  = 2'd2,
    ST_DOUBLE    = 2'd3
  } saa_status_t;

  typedef enum logic [2:0] {
    CMD_NOP  = 3'd0,
    CMD_CLR  = 3'd1,
    CMD_RD   = 3'd2,
    CMD_DESC = 3'd3,
    CMD_MARK = 3'd4,
    CMD_FREE = 3'd5
  } saa_op_t;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] address;
  } saa_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] assigned_address;
    logic [CNT_W-1:0]  free_count;
  } saa_rsp_t;

  typedef struct packed {
    saa_op_t           op;
    logic [LVL_W-1:0]  hbits;
    logic [NODE_W-1:0] path;
    logic [PAIR_W-1:0] clr_addr;
  } saa_cmd_t;

  typedef struct packed {
    logic              vld;
    logic [NODE_W-1:0] node;
  } saa_dn_t;

  typedef struct packed {
    logic vld;
    logic full;
  } saa_up_t;

endpackage

// ===== rtl/core/subnet_address_allocator.sv =====
// Subnet address allocator top level: request sequencer, registers and row of level cells.
// Host bits are at most 8; search and marking take one tree level per cycle. A release,
// or an allocate from a full pool, ends at the tree read; an allocate of a free requested
// host marks it; other allocates first search for the lowest free host. One request at
// a time, busy meanwhile. Reset and every register write start a clear sweep of the level
// stores, busy throughout. Results are strobed for one cycle and cannot be stalled.
module subnet_address_allocator import saa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  saa_req_t             in_req,
  output logic                 out_strobe,
  output saa_rsp_t             out_rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [ADDR_W-1:0]    cfg_data
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_RD     = 8'b0000_0100,
    S_RDWAIT = 8'b0000_1000,
    S_CHECK  = 8'b0001_0000,
    S_DESC   = 8'b0010_0000,
    S_MSTART = 8'b0100_0000,
    S_MARK   = 8'b1000_0000
  } saa_state_t;

  saa_state_t        state_r, state_nxt;
  logic [PAIR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0]  taken_r, taken_nxt;
  logic [ADDR_W-1:0] subnet_base_r;
  logic [PFX_W-1:0]  prefix_r;
  logic              req_r, req_nxt;
  logic [NODE_W-1:0] host_r, host_nxt;
  logic              strobe_r, strobe_nxt;
  saa_rsp_t          rsp_r, rsp_nxt;

  logic [5:0]         hb;
  logic [LVL_W-1:0]   h;
  logic [CNT_W-1:0]   base9;
  logic [NODE_W-1:0]  mask;
  logic [LVL_CNT-1:0] full_vec;
  logic               leaf;
  logic               root;
  saa_cmd_t           cmd;
  saa_dn_t            dn_o [LVL_CNT];
  saa_up_t            up_o [LVL_CNT];

  assign hb    = 6'd32 - {1'b0, prefix_r};
  assign h     = (hb > 6'(MAX_HOST_BITS)) ? LVL_W'(MAX_HOST_BITS) : LVL_W'(hb);
  assign base9 = CNT_W'(1) << h;
  assign mask  = NODE_W'(base9 - CNT_W'(1));
  assign leaf  = full_vec[h];
  assign root  = full_vec[0];

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_rsp    = rsp_r;

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    taken_nxt    = taken_r;
    req_nxt      = req_r;
    host_nxt     = host_r;
    strobe_nxt   = 1'b0;
    rsp_nxt      = rsp_r;
    cmd.op       = CMD_NOP;
    cmd.hbits    = h;
    cmd.path     = host_r;
    cmd.clr_addr = clr_cnt_r;
    case (state_r)
      S_CLEAR: begin
        cmd.op      = CMD_CLR;
        clr_cnt_nxt = clr_cnt_r + PAIR_W'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req.req_type;
          host_nxt  = NODE_W'(in_req.address) & mask;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.op    = CMD_RD;
        state_nxt = S_RDWAIT;
      end
      S_RDWAIT: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (req_r == REQ_ALLOC) begin
          if ((host_r != '0) && !leaf) begin
            state_nxt = S_MSTART;
          end else if (root) begin
            strobe_nxt               = 1'b1;
            rsp_nxt.status           = ST_EXHAUSTED;
            rsp_nxt.assigned_address = '0;
            rsp_nxt.free_count       = base9 - taken_r;
            state_nxt                = S_IDLE;
          end else begin
            cmd.op    = CMD_DESC;
            state_nxt = S_DESC;
          end
        end else begin
          strobe_nxt               = 1'b1;
          rsp_nxt.assigned_address = '0;
          state_nxt                = S_IDLE;
          if ((host_r == '0) || (host_r == mask)) begin
            rsp_nxt.status = ST_RESERVED;
          end else if (!leaf) begin
            rsp_nxt.status = ST_DOUBLE;
          end else begin
            cmd.op         = CMD_FREE;
            taken_nxt      = taken_r - CNT_W'(1);
            rsp_nxt.status = ST_OK;
          end
          rsp_nxt.free_count = base9 - taken_nxt;
        end
      end
      S_DESC: begin
        if (dn_o[h].vld) begin
          host_nxt  = dn_o[h].node;
          state_nxt = S_MSTART;
        end
      end
      S_MSTART: begin
        cmd.op    = CMD_MARK;
        state_nxt = S_MARK;
      end
      S_MARK: begin
        if (up_o[0].vld) begin
          taken_nxt                = taken_r + CNT_W'(1);
          strobe_nxt               = 1'b1;
          rsp_nxt.status           = ST_OK;
          rsp_nxt.assigned_address = subnet_base_r | ADDR_W'(host_r);
          rsp_nxt.free_count       = base9 - taken_nxt;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt   = S_CLEAR;
        clr_cnt_nxt = '0;
      end
    endcase
    // restart the sweep with the new subnet
    if (cfg_we) begin
      state_nxt   = S_CLEAR;
      clr_cnt_nxt = '0;
      taken_nxt   = TAKEN_RST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_cnt_r     <= '0;
      taken_r       <= TAKEN_RST;
      strobe_r      <= 1'b0;
      subnet_base_r <= '0;
      prefix_r      <= PREFIX_RST;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      taken_r   <= taken_nxt;
      strobe_r  <= strobe_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SUBNET_BASE:   subnet_base_r <= cfg_data;
          CFG_PREFIX_LENGTH: prefix_r      <= cfg_data[PFX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    host_r <= host_nxt;
    rsp_r  <= rsp_nxt;
  end

  for (genvar g = 0; g < LVL_CNT; g++) begin : g_cell
    saa_dn_t dn_in;
    saa_up_t up_in;

    if (g == 0) begin : g_first
      assign dn_in = '0;
    end else begin : g_mid
      assign dn_in = dn_o[g-1];
    end

    if (g == LVL_CNT - 1) begin : g_last
      assign up_in = '0;
    end else begin : g_low
      assign up_in = up_o[g+1];
    end

    saa_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .lvl       (LVL_W'(g)),
      .cmd       (cmd),
      .dn_in     (dn_in),
      .dn_out    (dn_o[g]),
      .up_in     (up_in),
      .up_out    (up_o[g]),
      .node_full (full_vec[g])
    );
  end

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> ($past(state_r) == S_CHECK || $past(state_r) == S_MARK))
    else $error("result strobe without a finishing request");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
    taken_r <= base9)
    else $error("taken count exceeds subnet size");

endmodule

// ===== rtl/core/saa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module saa_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/saa_cell.sv =====
// One tree level: sibling-pair store, path latch and up/down token hand-off.
module saa_cell import saa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LVL_W-1:0] lvl,
  input  saa_cmd_t         cmd,
  input  saa_dn_t          dn_in,
  output saa_dn_t          dn_out,
  input  saa_up_t          up_in,
  output saa_up_t          up_out,
  output logic             node_full
);

  logic              act;
  logic              is_rd;
  logic              desc_go;
  logic              rd_go;
  logic              mark_here;
  logic              mark_go;
  logic              v;
  logic              c;
  logic [LVL_W-1:0]  f_sh;
  logic [NODE_W-1:0] f_node;
  logic [NODE_W-1:0] hmask;
  logic [PAIR_W-1:0] half;
  logic [PAIR_W-1:0] raddr;
  logic [PAIR_W-1:0] waddr;
  logic              we;
  logic [1:0]        wdata;
  logic [1:0]        rdata;

  logic              rd_pend_r, rd_pend_nxt;
  logic              desc_r, desc_nxt;
  logic              sel_r, sel_nxt;
  logic [PAIR_W-1:0] addr_r, addr_nxt;
  logic [1:0]        pair_r, pair_nxt;
  saa_up_t           up_r, up_nxt;

  assign act       = (lvl <= cmd.hbits);
  assign is_rd     = (cmd.op == CMD_RD);
  assign desc_go   = (lvl == '0) ? (cmd.op == CMD_DESC) : dn_in.vld;
  assign rd_go     = act && (is_rd || desc_go);
  assign f_sh      = cmd.hbits - lvl;
  assign f_node    = cmd.path >> f_sh;
  assign raddr     = is_rd ? PAIR_W'(f_node >> 1) :
                     ((lvl == '0) ? '0 : PAIR_W'(dn_in.node));
  assign c         = (lvl == '0) ? 1'b0 : rdata[0];
  assign mark_here = (cmd.op == CMD_MARK) && (lvl == cmd.hbits);
  assign mark_go   = act && (mark_here || up_in.vld);
  assign v         = mark_here || up_in.full;
  assign hmask     = NODE_W'((CNT_W'(1) << cmd.hbits) - CNT_W'(1));
  assign half      = PAIR_W'(hmask >> 1);

  assign dn_out.vld  = rd_pend_r && desc_r;
  assign dn_out.node = NODE_W'({addr_r, c});
  assign up_out      = up_r;
  assign node_full   = pair_r[sel_r];

  always_comb begin
    we    = 1'b0;
    waddr = addr_r;
    wdata = pair_r;
    case (cmd.op)
      CMD_CLR: begin
        we       = 1'b1;
        waddr    = cmd.clr_addr;
        wdata[0] = (cmd.clr_addr == '0) &&
                   ((lvl == cmd.hbits) || ((lvl == '0) && (cmd.hbits == LVL_W'(1))));
        wdata[1] = (lvl == cmd.hbits) && (cmd.clr_addr == half);
      end
      CMD_FREE: begin
        we           = act;
        wdata[sel_r] = 1'b0;
      end
      default: begin
        if (mark_go) begin
          we           = 1'b1;
          wdata[sel_r] = v;
        end
      end
    endcase
  end

  always_comb begin
    rd_pend_nxt = rd_go;
    desc_nxt    = desc_r;
    sel_nxt     = sel_r;
    addr_nxt    = addr_r;
    pair_nxt    = pair_r;
    if (rd_pend_r) begin
      pair_nxt = rdata;
      if (desc_r) begin
        sel_nxt = c;
      end
    end
    if (rd_go) begin
      desc_nxt = !is_rd;
      addr_nxt = raddr;
      sel_nxt  = f_node[0];
    end
    up_nxt.vld  = mark_go;
    up_nxt.full = v & pair_r[~sel_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      up_r      <= '0;
    end else begin
      rd_pend_r <= rd_pend_nxt;
      up_r      <= up_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
    sel_r  <= sel_nxt;
    addr_r <= addr_nxt;
    pair_r <= pair_nxt;
  end

  saa_ram #(
    .WIDTH (2),
    .DEPTH (PAIR_CNT)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the subnet address allocator: directed and random requests.
`timescale 1ns / 1ps

module testbench;
  import saa_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned NUM_PHASES  = 10;

  class addr_pool_board;
    bit               full_mark [2 << MAX_HOST_BITS];
    int unsigned      taken;
    logic [31:0]      base_addr;
    logic [4:0]       prefix;
    saa_rsp_t         pending_replies [$];
    int unsigned      bad_replies;

    function new();
      base_addr   = '0;
      prefix      = PREFIX_RST;
      bad_replies = 0;
      clear_pool();
    endfunction

    function int unsigned host_width();
      int unsigned h;
      h = 32 - prefix;
      if (h > MAX_HOST_BITS) h = MAX_HOST_BITS;
      return h;
    endfunction

    function void set_leaf(int unsigned idx);
      full_mark[idx] = 1'b1;
      while (idx > 1) begin
        idx = idx >> 1;
        full_mark[idx] = full_mark[2 * idx] & full_mark[2 * idx + 1];
      end
    endfunction

    function void clear_path(int unsigned idx);
      while (idx >= 1) begin
        full_mark[idx] = 1'b0;
        idx = idx >> 1;
      end
    endfunction

    function void clear_pool();
      int unsigned span;
      span = 1 << host_width();
      foreach (full_mark[i]) full_mark[i] = 1'b0;
      set_leaf(span);
      set_leaf(2 * span - 1);
      taken = 2;
    endfunction

    function void write_reg(saa_cfg_idx_t idx, logic [31:0] data);
      case (idx)
        CFG_SUBNET_BASE: begin
          base_addr = data;
          clear_pool();
        end
        CFG_PREFIX_LENGTH: begin
          prefix = data[4:0];
          clear_pool();
        end
        default: ;
      endcase
    endfunction

    function void note_request(saa_req_t r);
      int unsigned span, mask, host, idx;
      saa_rsp_t    want;
      span = 1 << host_width();
      mask = span - 1;
      host = r.address & mask;
      want.status           = ST_OK;
      want.assigned_address = '0;
      if (r.req_type == REQ_ALLOC) begin
        if (host != 0 && !full_mark[span + host]) begin
          set_leaf(span + host);
          taken++;
          want.assigned_address = base_addr | host;
        end else if (full_mark[1]) begin
          want.status = ST_EXHAUSTED;
        end else begin
          idx = 1;
          for (int lvl = 0; lvl < host_width(); lvl++) begin
            idx = full_mark[2 * idx] ? 2 * idx + 1 : 2 * idx;
          end
          set_leaf(idx);
          taken++;
          want.assigned_address = base_addr | (idx - span);
        end
      end else begin
        if (host == 0 || host == mask) begin
          want.status = ST_RESERVED;
        end else if (!full_mark[span + host]) begin
          want.status = ST_DOUBLE;
        end else begin
          clear_path(span + host);
          taken--;
        end
      end
      want.free_count = CNT_W'(span - taken);
      pending_replies.push_back(want);
    endfunction

    function void check_reply(saa_rsp_t got);
      saa_rsp_t want;
      if (pending_replies.size() == 0) begin
        bad_replies++;
        if (bad_replies <= 10) $display("unexpected reply: status %0d addr %h free %0d",
                                        got.status, got.assigned_address, got.free_count);
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status || got.assigned_address !== want.assigned_address ||
          got.free_count !== want.free_count) begin
        bad_replies++;
        if (bad_replies <= 10)
          $display("reply mismatch: expected status %0d addr %h free %0d, got status %0d addr %h free %0d",
                   want.status, want.assigned_address, want.free_count,
                   got.status, got.assigned_address, got.free_count);
      end
    endfunction

    function int pick_taken_host();
      int unsigned span, first, host;
      span  = 1 << host_width();
      first = $urandom_range(span - 1);
      for (int unsigned k = 0; k < span; k++) begin
        host = (first + k) & (span - 1);
        if (host != 0 && host != span - 1 && full_mark[span + host]) return host;
      end
      return -1;
    endfunction

    function bit is_empty();
      return pending_replies.size() == 0;
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n    = 1'b0;
  logic                 start    = 1'b0;
  logic                 busy;
  saa_req_t             in_req   = '0;
  logic                 out_strobe;
  saa_rsp_t             out_rsp;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [ADDR_W-1:0]    cfg_data = '0;

  addr_pool_board board;
  int unsigned    cycle_count     = 0;
  int unsigned    sender_idle_pct = 0;

  int unsigned phase_prefix    [NUM_PHASES] = '{24, 31, 30, 28, 26, 24, 29, 27, 0, 25};
  int unsigned phase_items     [NUM_PHASES] = '{300, 40, 80, 120, 130, 150, 100, 110, 110, 110};
  int unsigned phase_alloc_pct [NUM_PHASES] = '{95, 60, 60, 65, 70, 55, 60, 70, 60, 65};

  subnet_address_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_reply(out_rsp);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic send_word(saa_req_type_t kind, logic [31:0] address);
    saa_req_t    r;
    int unsigned gap;
    r.req_type = kind;
    r.address  = address;
    gap        = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      gap++;
      @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    board.note_request(r);
  endtask

  task automatic send_random(int unsigned alloc_pct);
    logic [31:0]   mask, address;
    int            pick;
    saa_req_type_t kind;
    mask    = (32'd1 << board.host_width()) - 1;
    address = $urandom;
    if ($urandom_range(99) < alloc_pct) begin
      kind = REQ_ALLOC;
      if ($urandom_range(1) == 1) address = address & ~mask;
    end else begin
      kind = REQ_RELEASE;
      pick = board.pick_taken_host();
      if (pick >= 0 && $urandom_range(99) < 80) address = (address & ~mask) | pick;
    end
    send_word(kind, address);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (!board.is_empty()) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_register(saa_cfg_idx_t idx, logic [31:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    board.write_reg(idx, data);
    cfg_we <= 1'b0;
    do @(posedge clk); while (!busy);
    while (busy) @(posedge clk);
  endtask

  initial begin
    logic [31:0] base_val, prefix_val;
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (!busy);
    while (busy) @(posedge clk);

    // reset settings: 8 host bits, base zero
    send_word(REQ_ALLOC,   32'h0000_0000);
    send_word(REQ_ALLOC,   32'hFFFF_FFFF);
    send_word(REQ_ALLOC,   32'hFFFF_FF05);
    send_word(REQ_ALLOC,   32'h0000_0005);
    send_word(REQ_RELEASE, 32'h0000_0000);
    send_word(REQ_RELEASE, 32'hFFFF_FFFF);
    send_word(REQ_RELEASE, 32'h0000_00C8);
    send_word(REQ_RELEASE, 32'hABCD_EF05);
    send_word(REQ_RELEASE, 32'h0000_0005);
    send_word(REQ_ALLOC,   32'h0000_00FE);
    drain();

    // single host bit: no free host from the start
    set_register(CFG_SUBNET_BASE, 32'hFFFF_FFFF);
    set_register(CFG_PREFIX_LENGTH, 32'hFFFF_FFFF);
    send_word(REQ_ALLOC,   32'h0000_0000);
    send_word(REQ_ALLOC,   32'h0000_0001);
    send_word(REQ_RELEASE, 32'h0000_0001);
    send_word(REQ_RELEASE, 32'h0000_0000);
    drain();

    set_register(CFG_PREFIX_LENGTH, 32'd30);
    send_word(REQ_ALLOC,   32'h0000_0002);
    send_word(REQ_ALLOC,   32'h0000_0000);
    send_word(REQ_ALLOC,   32'h0000_0000);
    send_word(REQ_RELEASE, 32'h0000_0002);
    send_word(REQ_RELEASE, 32'h0000_0003);
    send_word(REQ_ALLOC,   32'h0000_0003);
    drain();

    // prefix below range: host width saturates
    set_register(CFG_SUBNET_BASE, 32'h5A5A_0000);
    set_register(CFG_PREFIX_LENGTH, 32'd0);
    send_word(REQ_ALLOC,   32'h0000_0000);
    send_word(REQ_RELEASE, 32'h0000_0080);
    send_word(REQ_ALLOC,   32'h0000_0080);
    send_word(REQ_RELEASE, 32'h0000_0080);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       base_val = 32'hFFFF_FFFF;
        1:       base_val = 32'h0000_0000;
        default: base_val = $urandom;
      endcase
      prefix_val = (32'($urandom) & 32'hFFFF_FFE0) | phase_prefix[p];
      if ($urandom_range(1) == 1) begin
        set_register(CFG_SUBNET_BASE, base_val);
        set_register(CFG_PREFIX_LENGTH, prefix_val);
      end else begin
        set_register(CFG_PREFIX_LENGTH, prefix_val);
        set_register(CFG_SUBNET_BASE, base_val);
      end
      case (p % 3)
        0:       sender_idle_pct = 0;
        1:       sender_idle_pct = 88;
        default: sender_idle_pct = 6;
      endcase
      for (int n = 0; n < phase_items[p]; n++) send_random(phase_alloc_pct[p]);
      drain();
    end

    repeat (40) @(posedge clk);
    if (board.bad_replies == 0 && board.is_empty()) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
